[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[rtl/htb_pkg.sv]
`default_nettype none

package htb_pkg;

  // Capacity of the live list
  localparam int unsigned MAX_SYMBOLS = 16;

  // Derived widths
  localparam int unsigned IDX_W = $clog2(MAX_SYMBOLS);
  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned IDW   = $clog2(2 * MAX_SYMBOLS);

  // Fixed field widths
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned LEAF_W_W = 16;
  localparam int unsigned WGT_W    = 20;
  localparam int unsigned ID_W     = 5;

  // Symbol reported for an internal node
  localparam logic [SYM_W-1:0] INTERNAL_SYM = 8'd35;

  // One live list entry
  typedef struct packed {
    logic [WGT_W-1:0] weight;
    logic [IDW-1:0]   id;
  } entry_t;

  // One merge result
  typedef struct packed {
    logic [ID_W-1:0]  left_id;
    logic [ID_W-1:0]  right_id;
    logic [SYM_W-1:0] left_symbol;
    logic [SYM_W-1:0] right_symbol;
    logic [WGT_W-1:0] merged_weight;
    logic [ID_W-1:0]  new_id;
    logic             overflow;
    logic             last_merge;
  } result_t;

  // Ids below the capacity are leaves
  function automatic logic is_leaf(input logic [IDW-1:0] id);
    is_leaf = (id < IDW'(MAX_SYMBOLS));
  endfunction

endpackage

`default_nettype wire

[rtl/htb_ram.sv]
`default_nettype none

// Simple dual-port memory: one write, one registered read
module htb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/htb_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"

// Load sequencer and build engine: one comparator and one adder walk the live list
module htb_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [htb_pkg::SYM_W-1:0]     in_symbol_i,
  input  wire logic [htb_pkg::LEAF_W_W-1:0]  in_weight_i,
  input  wire logic                          in_last_i,
  input  wire logic                          out_free_i,
  output logic                               push_o,
  output htb_pkg::result_t                   res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDI   = 4'd1;
  localparam logic [3:0] S_LDI   = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_WRI   = 4'd4;
  localparam logic [3:0] S_RD0   = 4'd5;
  localparam logic [3:0] S_RD1   = 4'd6;
  localparam logic [3:0] S_SYML  = 4'd7;
  localparam logic [3:0] S_SYMR  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_SHIFT = 4'd10;

  localparam int unsigned IDX_W = htb_pkg::IDX_W;
  localparam int unsigned CNT_W = htb_pkg::CNT_W;
  localparam int unsigned IDW   = htb_pkg::IDW;
  localparam int unsigned WGT_W = htb_pkg::WGT_W;
  localparam int unsigned SYM_W = htb_pkg::SYM_W;
  localparam int unsigned ID_W  = htb_pkg::ID_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(htb_pkg::MAX_SYMBOLS);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] p_q, p_d;
  logic [IDX_W-1:0] k_q, k_d;
  htb_pkg::entry_t  cur_q, cur_d;
  htb_pkg::entry_t  e0_q, e0_d;
  htb_pkg::entry_t  e1_q, e1_d;
  logic [SYM_W-1:0] lsym_q, lsym_d;

  // Live list memory ports
  logic             lst_we, lst_re;
  logic [IDX_W-1:0] lst_waddr, lst_raddr;
  htb_pkg::entry_t  lst_wdata, lst_rdata;

  // Leaf symbol memory ports
  logic             sym_we, sym_re;
  logic [IDX_W-1:0] sym_waddr, sym_raddr;
  logic [SYM_W-1:0] sym_rdata;

  // Shared arithmetic
  logic             swap;
  logic [WGT_W-1:0] sum;
  logic [IDW-1:0]   new_id;
  logic [CNT_W-1:0] n_load, j_next, p_next;

  htb_ram #(.WIDTH($bits(htb_pkg::entry_t)), .DEPTH(htb_pkg::MAX_SYMBOLS)) u_list (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (lst_waddr),
    .wdata_i (lst_wdata),
    .re_i    (lst_re),
    .raddr_i (lst_raddr),
    .rdata_o (lst_rdata)
  );

  htb_ram #(.WIDTH(SYM_W), .DEPTH(htb_pkg::MAX_SYMBOLS)) u_sym (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (sym_waddr),
    .wdata_i (in_symbol_i),
    .re_i    (sym_re),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  assign swap   = (cur_q.weight > lst_rdata.weight);
  assign sum    = e0_q.weight + e1_q.weight;
  assign new_id = IDW'(htb_pkg::MAX_SYMBOLS) + IDW'(k_q);
  assign n_load = (cnt_q < CAP) ? cnt_q + CNT_W'(1) : cnt_q;
  assign j_next = j_q + CNT_W'(1);
  assign p_next = p_q + CNT_W'(1);

  assign in_ready_o = (state_q == S_IDLE);

  // Result fields
  always_comb begin
    res_o.left_id       = ID_W'(e0_q.id);
    res_o.right_id      = ID_W'(e1_q.id);
    res_o.left_symbol   = lsym_q;
    res_o.right_symbol  = htb_pkg::is_leaf(e1_q.id) ? sym_rdata : htb_pkg::INTERNAL_SYM;
    res_o.merged_weight = sum;
    res_o.new_id        = ID_W'(new_id);
    res_o.overflow      = ovf_q;
    res_o.last_merge    = (cnt_q == CNT_W'(2));
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    p_d       = p_q;
    k_d       = k_q;
    cur_d     = cur_q;
    e0_d      = e0_q;
    e1_d      = e1_q;
    lsym_d    = lsym_q;
    lst_we    = 1'b0;
    lst_waddr = '0;
    lst_wdata = cur_q;
    lst_re    = 1'b0;
    lst_raddr = '0;
    sym_we    = 1'b0;
    sym_waddr = cnt_q[IDX_W-1:0];
    sym_re    = 1'b0;
    sym_raddr = '0;
    push_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // Store the leaf, or drop it when full
          if (cnt_q < CAP) begin
            lst_we           = 1'b1;
            lst_waddr        = cnt_q[IDX_W-1:0];
            lst_wdata.weight = WGT_W'(in_weight_i);
            lst_wdata.id     = IDW'(cnt_q);
            sym_we           = 1'b1;
            cnt_d            = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            i_d = '0;
            k_d = '0;
            if (n_load >= CNT_W'(2)) begin
              state_d = S_RDI;
            end else begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
          end
        end
      end
      S_RDI: begin
        lst_re    = 1'b1;
        lst_raddr = i_q;
        state_d   = S_LDI;
      end
      S_LDI: begin
        // Hold position i in a register while j sweeps
        cur_d     = lst_rdata;
        j_d       = CNT_W'(i_q) + CNT_W'(1);
        lst_re    = 1'b1;
        lst_raddr = i_q + IDX_W'(1);
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (swap) begin
          lst_we    = 1'b1;
          lst_waddr = j_q[IDX_W-1:0];
          lst_wdata = cur_q;
          cur_d     = lst_rdata;
        end
        if (j_next < cnt_q) begin
          j_d       = j_next;
          lst_re    = 1'b1;
          lst_raddr = j_next[IDX_W-1:0];
        end else begin
          state_d = S_WRI;
        end
      end
      S_WRI: begin
        lst_we    = 1'b1;
        lst_waddr = i_q;
        lst_wdata = cur_q;
        if (CNT_W'(i_q) + CNT_W'(2) < cnt_q) begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_RDI;
        end else begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        lst_re    = 1'b1;
        lst_raddr = '0;
        state_d   = S_RD1;
      end
      S_RD1: begin
        e0_d      = lst_rdata;
        lst_re    = 1'b1;
        lst_raddr = IDX_W'(1);
        state_d   = S_SYML;
      end
      S_SYML: begin
        e1_d      = lst_rdata;
        sym_re    = 1'b1;
        sym_raddr = e0_q.id[IDX_W-1:0];
        state_d   = S_SYMR;
      end
      S_SYMR: begin
        lsym_d    = htb_pkg::is_leaf(e0_q.id) ? sym_rdata : htb_pkg::INTERNAL_SYM;
        sym_re    = 1'b1;
        sym_raddr = e1_q.id[IDX_W-1:0];
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          // Emit the merge and put the new node at the head
          push_o           = 1'b1;
          lst_we           = 1'b1;
          lst_waddr        = '0;
          lst_wdata.weight = sum;
          lst_wdata.id     = new_id;
          k_d              = k_q + IDX_W'(1);
          if (cnt_q == CNT_W'(2)) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            k_d     = '0;
            state_d = S_IDLE;
          end else begin
            cnt_d     = cnt_q - CNT_W'(1);
            p_d       = CNT_W'(1);
            lst_re    = 1'b1;
            lst_raddr = IDX_W'(2);
            state_d   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // Move entries from position 2 onward down one place
        lst_we    = 1'b1;
        lst_waddr = p_q[IDX_W-1:0];
        lst_wdata = lst_rdata;
        if (p_next < cnt_q) begin
          p_d       = p_next;
          lst_re    = 1'b1;
          lst_raddr = p_next[IDX_W-1:0] + IDX_W'(1);
        end else begin
          i_d     = '0;
          state_d = S_RDI;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      p_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      p_q     <= p_d;
      k_q     <= k_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    e0_q   <= e0_d;
    e1_q   <= e1_d;
    lsym_q <= lsym_d;
  end

  `ASSERT_ALWAYS(a_push_free, clk_i, rst_ni, push_o |-> out_free_i, "result pushed into busy output stage")
  `ASSERT_NEVER(a_cnt_cap, clk_i, rst_ni, cnt_q > CAP, "live count above capacity")
  `ASSERT_ALWAYS(a_cmp_range, clk_i, rst_ni, (state_q == S_CMP) |-> (j_q > CNT_W'(i_q) && j_q < cnt_q), "sweep index out of range")
  `ASSERT_ALWAYS(a_root_idle, clk_i, rst_ni, (push_o && res_o.last_merge) |=> (state_q == S_IDLE && cnt_q == '0 && !ovf_q), "build did not finish after root")

endmodule

`default_nettype wire

[rtl/huffman_tree_builder.sv]
`default_nettype none

// Huffman tree builder. Leaves arrive one per item on the slave side and are
// stored in a 16-entry live list at one item per cycle while idle; the leaf
// with tlast set starts the build (with fewer than two leaves stored it clears
// the list instead) and the input stays not ready until the root is emitted.
// For each merge the list is re-sorted by an exchange sort that keeps position
// i in a register and sweeps j through a list memory with one read and one
// write port, using one weight comparator; the two lowest entries and then
// their symbols are read, the merge is handed to the output stage (waiting
// while that stage is held), and unless it was the root the list is shifted
// down one place. One result per merge leaves through a registered master
// stage; tlast marks the root and tuser flags that leaves were dropped
// because the list was full.
module huffman_tree_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // symbol[7:0], weight[23:8]
  input  wire logic        s_axis_tlast,  // last_leaf
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // left_id[4:0], right_id[9:5], left_symbol[17:10], right_symbol[25:18],
  // merged_weight[45:26], new_id[50:46], zero pad[55:51]
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tuser,  // overflow
  output logic             m_axis_tlast   // last_merge
);

  logic             push;
  logic             out_free;
  htb_pkg::result_t res;
  htb_pkg::result_t res_q;
  logic             valid_q;

  htb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_symbol_i (s_axis_tdata[7:0]),
    .in_weight_i (s_axis_tdata[23:8]),
    .in_last_i   (s_axis_tlast),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res)
  );

  assign out_free = !valid_q || m_axis_tready;

  // Output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free) begin
      valid_q <= push;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'd0, res_q.new_id, res_q.merged_weight, res_q.right_symbol,
                          res_q.left_symbol, res_q.right_id, res_q.left_id};
  assign m_axis_tuser  = res_q.overflow;
  assign m_axis_tlast  = res_q.last_merge;

endmodule

`default_nettype wire
